// ===== design/m4mr_pkg.sv =====
// Package for the 4x4 row-by-row matrix multiplier.
// Holds the shared widths, request codes and lane control struct.
// No dependencies.
`timescale 1ns / 1ps

package m4mr_pkg;

    localparam int DIM       = 4;
    localparam int ELEM_W    = 32;
    localparam int ROW_W     = 2;
    localparam int FRAC_BITS = 16;

    // full product, shifted product and sum of DIM shifted products
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SH_W + $clog2(DIM);

    localparam int DATA_BITS = ROW_W + DIM * ELEM_W;
    localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_MUL  = 1'b1
    } t_req;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_lane_ctrl;

endpackage

// ===== design/m4mr_lane.sv =====
// One column lane: four signed products, then floor shift, sum and saturate.
// Depends on m4mr_pkg.
`timescale 1ns / 1ps

module m4mr_lane (
    input  logic                                    i_clk,
    input  m4mr_pkg::t_lane_ctrl                    i_ctrl,
    input  logic signed [m4mr_pkg::ELEM_W-1:0]      i_a [m4mr_pkg::DIM],
    input  logic signed [m4mr_pkg::ELEM_W-1:0]      i_b [m4mr_pkg::DIM],
    output logic signed [m4mr_pkg::ELEM_W-1:0]      o_res,
    output logic                                    o_sat
);

    logic signed [m4mr_pkg::PROD_W-1:0] r_prod [m4mr_pkg::DIM];
    logic signed [m4mr_pkg::PROD_W-1:0] n_prod [m4mr_pkg::DIM];
    logic signed [m4mr_pkg::SUM_W-1:0]  w_sum;
    logic signed [m4mr_pkg::ELEM_W-1:0] n_res;
    logic                               n_sat;
    logic signed [m4mr_pkg::ELEM_W-1:0] r_res;
    logic                               r_sat;

    always_comb begin
        for (int i = 0; i < m4mr_pkg::DIM; i++) begin
            n_prod[i] = i_a[i] * i_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            r_prod <= n_prod;
        end
    end

    // drop the fraction bits (arithmetic, rounds toward minus infinity) and add
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < m4mr_pkg::DIM; i++) begin
            w_sum = w_sum + m4mr_pkg::SUM_W'(
                signed'(r_prod[i][m4mr_pkg::PROD_W-1:m4mr_pkg::FRAC_BITS]));
        end
    end

    // out of range when the bits above the result sign differ from it
    always_comb begin
        n_sat = (w_sum[m4mr_pkg::SUM_W-1:m4mr_pkg::ELEM_W-1] != '0) &&
                (w_sum[m4mr_pkg::SUM_W-1:m4mr_pkg::ELEM_W-1] != '1);
        if (n_sat) begin
            n_res = w_sum[m4mr_pkg::SUM_W-1] ?
                    {1'b1, {(m4mr_pkg::ELEM_W-1){1'b0}}} :
                    {1'b0, {(m4mr_pkg::ELEM_W-1){1'b1}}};
        end else begin
            n_res = w_sum[m4mr_pkg::ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

// ===== design/m4mr_merge.sv =====
// Merge stage: combines the lane results into one result word and holds it
// in the output register until taken. Depends on m4mr_pkg.
`timescale 1ns / 1ps

module m4mr_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [m4mr_pkg::ROW_W-1:0]              i_row,
    input  logic signed [m4mr_pkg::ELEM_W-1:0]      i_res [m4mr_pkg::DIM],
    input  logic [m4mr_pkg::DIM-1:0]                i_sat,
    output logic                                    o_tvalid,
    input  logic                                    i_tready,
    output logic [m4mr_pkg::DATA_W-1:0]             o_tdata,
    output logic [0:0]                              o_tuser
);

    logic                          r_valid;
    logic [m4mr_pkg::DATA_W-1:0]   r_data;
    logic [m4mr_pkg::DATA_W-1:0]   n_data;
    logic                          r_flag;

    assign o_ready = !r_valid || i_tready;

    always_comb begin
        n_data = '0;
        n_data[m4mr_pkg::ROW_W-1:0] = i_row;
        for (int c = 0; c < m4mr_pkg::DIM; c++) begin
            n_data[m4mr_pkg::ROW_W + c*m4mr_pkg::ELEM_W +: m4mr_pkg::ELEM_W] = i_res[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
            r_flag <= |i_sat;
        end
    end

    assign o_tvalid   = r_valid;
    assign o_tdata    = r_data;
    assign o_tuser[0] = r_flag;

endmodule

// ===== design/mat4_multiply_rows_top.sv =====
// Top level of the 4x4 row-by-row matrix multiplier.
// Depends on m4mr_pkg, m4mr_lane and m4mr_merge.
`timescale 1ns / 1ps

// Takes one word per clock unless the output side applies backpressure.
// A load word (tuser = 0) writes one row of the stored right-hand matrix,
// which resets to all zero, and returns nothing; the new row is used by
// any multiply word accepted after it. A multiply word (tuser = 1) carries
// one left-hand row and returns one result row, in Q16.16 with each
// product floored and each column sum saturated. Four column lanes of
// four 32x32 multipliers each compute the row at once: a product register
// stage, a sum and saturate stage, then the output register, so the block
// sustains one word per cycle and stalls only on backpressure.
module mat4_multiply_rows_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // row_index[1:0], elem_0[33:2], elem_1[65:34], elem_2[97:66],
    // elem_3[129:98], zero pad
    input  logic [m4mr_pkg::DATA_W-1:0]         i_s_tdata,
    // req_type[0]
    input  logic [0:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // out_row[1:0], prod_0[33:2], prod_1[65:34], prod_2[97:66],
    // prod_3[129:98], zero pad
    output logic [m4mr_pkg::DATA_W-1:0]         o_m_tdata,
    // saturated[0]
    output logic [0:0]                          o_m_tuser
);

    localparam int DIM    = m4mr_pkg::DIM;
    localparam int ELEM_W = m4mr_pkg::ELEM_W;
    localparam int ROW_W  = m4mr_pkg::ROW_W;

    logic signed [ELEM_W-1:0] r_mat [DIM][DIM];
    logic signed [ELEM_W-1:0] w_a   [DIM];
    logic signed [ELEM_W-1:0] w_col [DIM][DIM];
    logic signed [ELEM_W-1:0] w_res [DIM];
    logic [DIM-1:0]           w_sat;
    logic [ROW_W-1:0]         w_row;
    m4mr_pkg::t_req           w_req;
    m4mr_pkg::t_lane_ctrl     w_ctrl;

    logic             r_v1, r_v2;
    logic [ROW_W-1:0] r_row1, r_row2;
    logic             w_rdy1, w_rdy2, w_rdy_out;
    logic             w_accept;

    assign w_row = i_s_tdata[ROW_W-1:0];
    assign w_req = m4mr_pkg::t_req'(i_s_tuser[0]);

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            w_a[i] = i_s_tdata[ROW_W + i*ELEM_W +: ELEM_W];
        end
        for (int c = 0; c < DIM; c++) begin
            for (int i = 0; i < DIM; i++) begin
                w_col[c][i] = r_mat[i][c];
            end
        end
    end

    // advance a stage when the next one is empty or moving
    assign w_rdy2      = !r_v2 || w_rdy_out;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign o_s_tready  = w_rdy1;
    assign w_accept    = i_s_tvalid && w_rdy1;
    assign w_ctrl.en_mul = w_rdy1;
    assign w_ctrl.en_sum = w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM; i++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_mat[i][c] <= '0;
                end
            end
        end else if (w_accept && w_req == m4mr_pkg::REQ_LOAD) begin
            for (int c = 0; c < DIM; c++) begin
                r_mat[w_row][c] <= w_a[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= w_accept && w_req == m4mr_pkg::REQ_MUL;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_row1 <= w_row;
        end
        if (w_rdy2) begin
            r_row2 <= r_row1;
        end
    end

    for (genvar c = 0; c < DIM; c++) begin : g_lane
        m4mr_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_a    (w_a),
            .i_b    (w_col[c]),
            .o_res  (w_res[c]),
            .o_sat  (w_sat[c])
        );
    end

    m4mr_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v2),
        .o_ready  (w_rdy_out),
        .i_row    (r_row2),
        .i_res    (w_res),
        .i_sat    (w_sat),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser)
    );

endmodule

// ===== design/m4mr_checker.sv =====
// Port-level checks for the 4x4 row-by-row matrix multiplier, bound to the
// top level. Depends on m4mr_pkg and mat4_multiply_rows_top.
`timescale 1ns / 1ps

module m4mr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic [m4mr_pkg::DATA_W-1:0]   i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [m4mr_pkg::DATA_W-1:0]   o_m_tdata,
    input  logic [0:0]                    o_m_tuser
);

    localparam int LO = m4mr_pkg::ROW_W;
    localparam int W  = m4mr_pkg::ELEM_W;
    localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with output side empty");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            o_m_tdata[LO +: W] == S_MAX || o_m_tdata[LO +: W] == S_MIN ||
            o_m_tdata[LO+W +: W] == S_MAX || o_m_tdata[LO+W +: W] == S_MIN ||
            o_m_tdata[LO+2*W +: W] == S_MAX || o_m_tdata[LO+2*W +: W] == S_MIN ||
            o_m_tdata[LO+3*W +: W] == S_MAX || o_m_tdata[LO+3*W +: W] == S_MIN)
        else $error("saturated flag without a clipped column");

endmodule

bind mat4_multiply_rows_top m4mr_checker u_m4mr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== bench/m4mr_row_checker.sv =====
// Scoreboard for the 4x4 row-by-row matrix multiplier bench.
// Tracks its own copy of the right-hand matrix, predicts each result row
// and compares it with the output stream. Depends on m4mr_pkg.
`timescale 1ns / 1ps

module m4mr_row_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_tvalid,
    input  logic                        i_in_tready,
    // row_index[1:0], elem_0..elem_3 from bit 2 up, zero pad
    input  logic [m4mr_pkg::DATA_W-1:0] i_in_tdata,
    // req_type[0]
    input  logic [0:0]                  i_in_tuser,
    input  logic                        i_out_tvalid,
    input  logic                        i_out_tready,
    // out_row[1:0], prod_0..prod_3 from bit 2 up, zero pad
    input  logic [m4mr_pkg::DATA_W-1:0] i_out_tdata,
    // saturated[0]
    input  logic [0:0]                  i_out_tuser,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_load_count,
    output int                          o_mul_count,
    output int                          o_sat_count,
    output int                          o_checked_count
);

    import m4mr_pkg::*;

    typedef struct {
        logic [ROW_W-1:0]         row;
        logic signed [ELEM_W-1:0] prod [DIM];
        logic                     sat;
    } t_row_result;

    logic signed [ELEM_W-1:0] right_rows [DIM][DIM];
    t_row_result              expected_rows [$];
    t_row_result              want;
    t_row_result              got;
    t_req                     kind;
    logic [ROW_W-1:0]         in_row;
    logic signed [ELEM_W-1:0] in_elem [DIM];
    logic                     bad;

    // Dot products of one left-hand row with each column of the stored matrix:
    // floor each product by the fraction bits, then clip the sum to 32 bits.
    function automatic t_row_result mul_row_predict(
        input logic [ROW_W-1:0]         row,
        input logic signed [ELEM_W-1:0] a [DIM]
    );
        t_row_result              r;
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] bx;
        logic signed [PROD_W-1:0] acc;
        r.row = row;
        r.sat = 1'b0;
        for (int c = 0; c < DIM; c++) begin
            acc = '0;
            for (int i = 0; i < DIM; i++) begin
                ax  = a[i];
                bx  = right_rows[i][c];
                acc = acc + ((ax * bx) >>> FRAC_BITS);
            end
            if (acc > 64'sh0000_0000_7FFF_FFFF) begin
                r.prod[c] = 32'sh7FFF_FFFF;
                r.sat     = 1'b1;
            end else if (acc < -64'sh0000_0000_8000_0000) begin
                r.prod[c] = 32'sh8000_0000;
                r.sat     = 1'b1;
            end else begin
                r.prod[c] = acc[ELEM_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM; i++) begin
                for (int c = 0; c < DIM; c++) begin
                    right_rows[i][c] = '0;
                end
            end
            expected_rows.delete();
            o_fail_count    = 0;
            o_load_count    = 0;
            o_mul_count     = 0;
            o_sat_count     = 0;
            o_checked_count = 0;
        end else begin
            // Check the output first: a result never belongs to a same-edge input.
            if (i_out_tvalid && i_out_tready) begin
                got.row = i_out_tdata[ROW_W-1:0];
                for (int c = 0; c < DIM; c++) begin
                    got.prod[c] = i_out_tdata[ROW_W + c*ELEM_W +: ELEM_W];
                end
                got.sat = i_out_tuser[0];
                if (expected_rows.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result row %0d: %h %h %h %h sat %0d",
                                 got.row, got.prod[0], got.prod[1], got.prod[2],
                                 got.prod[3], got.sat);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    bad  = (want.row != got.row) || (want.sat != got.sat);
                    for (int c = 0; c < DIM; c++) begin
                        bad = bad || (want.prod[c] != got.prod[c]);
                    end
                    if (bad) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch row exp %0d got %0d, sat exp %0d got %0d",
                                     want.row, got.row, want.sat, got.sat);
                            $display("  exp %h %h %h %h", want.prod[0], want.prod[1],
                                     want.prod[2], want.prod[3]);
                            $display("  got %h %h %h %h", got.prod[0], got.prod[1],
                                     got.prod[2], got.prod[3]);
                        end
                        o_fail_count++;
                    end
                    o_checked_count++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                kind   = t_req'(i_in_tuser[0]);
                in_row = i_in_tdata[ROW_W-1:0];
                for (int c = 0; c < DIM; c++) begin
                    in_elem[c] = i_in_tdata[ROW_W + c*ELEM_W +: ELEM_W];
                end
                if (kind == REQ_LOAD) begin
                    for (int c = 0; c < DIM; c++) begin
                        right_rows[in_row][c] = in_elem[c];
                    end
                    o_load_count++;
                end else begin
                    want = mul_row_predict(in_row, in_elem);
                    if (want.sat) begin
                        o_sat_count++;
                    end
                    expected_rows.push_back(want);
                    o_mul_count++;
                end
            end
        end
        o_pending = expected_rows.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the 4x4 row-by-row matrix multiplier bench: clock, reset, stimulus
// with bursty input and stalling output, watchdog and verdict.
// Depends on m4mr_pkg, mat4_multiply_rows_top and m4mr_row_checker.
`timescale 1ns / 1ps

module testbench;

    import m4mr_pkg::*;

    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              RANDOM_ROWS    = 600;
    localparam logic [ELEM_W-1:0] ONE_Q   = 32'h0001_0000;
    localparam logic [ELEM_W-1:0] NEG_ONE = 32'hFFFF_0000;
    localparam logic [ELEM_W-1:0] MAX_Q   = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] MIN_Q   = 32'h8000_0000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;
    logic [0:0]        i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [DATA_W-1:0] o_m_tdata;
    logic [0:0]        o_m_tuser;

    int fail_count;
    int pending;
    int load_count;
    int mul_count;
    int sat_count;
    int checked_count;
    int burst_left;
    int idle_cycles;

    mat4_multiply_rows_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    m4mr_row_checker scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_tvalid     (i_s_tvalid),
        .i_in_tready     (o_s_tready),
        .i_in_tdata      (i_s_tdata),
        .i_in_tuser      (i_s_tuser),
        .i_out_tvalid    (o_m_tvalid),
        .i_out_tready    (i_m_tready),
        .i_out_tdata     (o_m_tdata),
        .i_out_tuser     (o_m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_load_count    (load_count),
        .o_mul_count     (mul_count),
        .o_sat_count     (sat_count),
        .o_checked_count (checked_count)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mix of Q16.16 magnitudes: mostly small enough to stay in range, some
    // large or extreme enough to saturate, some raw full-width patterns.
    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            3, 4:    return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            5:       return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            6, 7:    return 32'($urandom);
            8: begin
                case ($urandom_range(0, 5))
                    0:       return MAX_Q;
                    1:       return MIN_Q;
                    2:       return ONE_Q;
                    3:       return NEG_ONE;
                    4:       return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return 32'($urandom_range(0, 64)) - 32'd32;
        endcase
    endfunction

    // Drive one word at a falling edge, hold it until accepted.
    task automatic send_row(input t_req kind, input logic [ROW_W-1:0] row,
                            input logic [DIM-1:0][ELEM_W-1:0] elems);
        int                gap;
        logic [DATA_W-1:0] word;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
        word                         = '0;
        word[ROW_W-1:0]              = row;
        word[ROW_W +: DIM*ELEM_W]    = elems;
        i_s_tdata                    = word;
        i_s_tuser                    = kind;
        i_s_tvalid                   = 1'b1;
        burst_left--;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Output side: segments of always-ready, random, mostly-stalled and
    // fixed-pattern backpressure.
    initial begin
        int         mode;
        int         span;
        logic [7:0] mask;
        logic [2:0] phase;
        i_m_tready = 1'b0;
        phase      = '0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            mask = 8'($urandom);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_m_tready = 1'b1;
                    1:       i_m_tready = 1'($urandom_range(0, 1));
                    2:       i_m_tready = ($urandom_range(0, 3) == 0);
                    default: i_m_tready = mask[phase];
                endcase
                phase++;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [DIM-1:0][ELEM_W-1:0] elems;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = REQ_LOAD;
        burst_left = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Cleared matrix gives zero rows whatever the left side holds.
        send_row(REQ_MUL, 2'd0, {MIN_Q, MAX_Q, NEG_ONE, ONE_Q});

        // Identity: rows pass through unchanged, negatives included.
        for (int r = 0; r < DIM; r++) begin
            elems    = '0;
            elems[r] = ONE_Q;
            send_row(REQ_LOAD, 2'(r), elems);
        end
        send_row(REQ_MUL, 2'd1, {32'd1, 32'hFFFF_FFFF, MIN_Q, MAX_Q});

        // All-max matrix: clip high, clip low, and floor of tiny raw values.
        for (int r = 0; r < DIM; r++) begin
            send_row(REQ_LOAD, 2'(r), {DIM{MAX_Q}});
        end
        send_row(REQ_MUL, 2'd2, {DIM{MAX_Q}});
        send_row(REQ_MUL, 2'd3, {DIM{MIN_Q}});
        send_row(REQ_MUL, 2'd0, {DIM{32'd1}});
        send_row(REQ_MUL, 2'd1, {DIM{32'hFFFF_FFFF}});

        // Mixed signs at the extremes.
        send_row(REQ_LOAD, 2'd2, {DIM{MIN_Q}});
        send_row(REQ_MUL, 2'd3, {DIM{MIN_Q}});
        send_row(REQ_MUL, 2'd2, {MIN_Q, MAX_Q, MIN_Q, MAX_Q});

        // Negative products round toward minus infinity.
        send_row(REQ_LOAD, 2'd0, {32'd0, 32'd0, 32'd3, 32'd1});
        for (int r = 1; r < DIM; r++) begin
            send_row(REQ_LOAD, 2'(r), '0);
        end
        send_row(REQ_MUL, 2'd2, {MIN_Q, MAX_Q, 32'h1234_5678, 32'hFFFF_FFFF});
        send_row(REQ_MUL, 2'd3, {32'd0, 32'd0, 32'd0, 32'hFFFE_0001});

        for (int n = 0; n < RANDOM_ROWS; n++) begin
            for (int c = 0; c < DIM; c++) begin
                elems[c] = rand_elem();
            end
            send_row(($urandom_range(0, 2) == 0) ? REQ_LOAD : REQ_MUL,
                     2'($urandom_range(0, 3)), elems);
        end

        i_s_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run: %0d row loads, %0d row multiplies, %0d of them saturated",
                 load_count, mul_count, sat_count);
        $display("checked %0d result rows, %0d failures, %0d still expected",
                 checked_count, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== mat4_multiply_rows_top.f =====
design/m4mr_pkg.sv
design/m4mr_lane.sv
design/m4mr_merge.sv
design/mat4_multiply_rows_top.sv
design/m4mr_checker.sv
bench/m4mr_row_checker.sv
bench/testbench.sv
